>>> src/twgm_pkg.sv
// ----------------------------------------------------------------------------
// twgm_pkg
// Shared widths, register indexes, reset values and solver types for the
// two-walker grid collector.
// ----------------------------------------------------------------------------
package twgm_pkg;

    localparam int VALUE_W    = 16;
    localparam int TOTAL_W    = 23;
    localparam int ROWS_CFG_W = 7;
    localparam int COLS_CFG_W = 5;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'd1;

    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 7'd64;
    localparam logic [COLS_CFG_W-1:0] COLS_RESET = 5'd16;

    typedef enum logic [2:0] {
        SOLVE_IDLE,
        SOLVE_ROW_RD,
        SOLVE_ROW_LD,
        SOLVE_COL_RD,
        SOLVE_COL_LD,
        SOLVE_PAIR,
        SOLVE_PAIR_END,
        SOLVE_WRITE
    } t_solve_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_solve_status;

endpackage

>>> src/twgm_ram.sv
// ----------------------------------------------------------------------------
// twgm_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module twgm_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/twgm_solver.sv
// ----------------------------------------------------------------------------
// twgm_solver
// Bottom-up pass over the grid rows. Each layer row (fixed col1, all col2) is
// one word of the layer RAM; two banks alternate as the row below and the row
// being built. A three-word window feeds the nine-way max, one pair a cycle.
// ----------------------------------------------------------------------------
module twgm_solver #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 16
) (
    i_clk,
    i_rst_n,
    i_start,
    i_rows,
    i_cols,
    i_base,
    o_grid_raddr,
    i_grid_rdata,
    o_status,
    o_total
);

    localparam int GD  = MAX_ROWS * MAX_COLS;
    localparam int GAW = (GD > 1) ? $clog2(GD) : 1;
    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int NW  = $clog2(MAX_COLS + 1);
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int LAW = CW + 1;
    localparam int TW  = twgm_pkg::TOTAL_W;
    localparam int LDW = MAX_COLS * TW;

    input  logic                          i_clk;
    input  logic                          i_rst_n;
    input  logic                          i_start;
    input  logic [RW-1:0]                 i_rows;
    input  logic [NW-1:0]                 i_cols;
    input  logic [GAW-1:0]                i_base;
    output logic [GAW-1:0]                o_grid_raddr;
    input  logic [twgm_pkg::VALUE_W-1:0]  i_grid_rdata;
    output twgm_pkg::t_solve_status       o_status;
    output logic [TW-1:0]                 o_total;

    typedef logic [MAX_COLS-1:0][TW-1:0] t_layer_word;

    twgm_pkg::t_solve_state r_state, n_state;

    logic [RW-1:0]          r_row;
    logic [GAW-1:0]         r_base;
    logic [NW-1:0]          r_nc;
    logic [CW-1:0]          r_a;
    logic [CW-1:0]          r_b;
    logic [CW-1:0]          r_b_d;
    logic                   r_bd_vld;
    logic                   r_first;
    logic                   r_bank;
    logic [twgm_pkg::VALUE_W-1:0] r_ga;
    logic [TW-1:0]          r_best;
    t_layer_word            r_prev, r_cur, r_nxt, r_word;
    t_layer_word            w_win [3];
    t_layer_word            w_lay_rdata;

    logic [LDW-1:0]         w_lay_rdata_raw;
    logic [LAW-1:0]         w_lay_raddr;
    logic [LAW-1:0]         w_lay_waddr;
    logic                   w_lay_we;
    logic [TW-1:0]          w_max9;
    logic                   w_last_b;
    logic                   w_last_a;
    logic                   w_a1_in;
    logic [CW-1:0]          w_a1;
    logic [CW-1:0]          w_nc_m1;

    assign w_a1     = CW'(r_a + 1'b1);
    assign w_a1_in  = (NW'(r_a) + 1'b1) < r_nc;
    assign w_nc_m1  = CW'(r_nc - 1'b1);
    assign w_last_b = (r_b == w_nc_m1);
    assign w_last_a = (r_a == w_nc_m1);

    // read bank holds the row below, the other bank takes the new row
    assign w_lay_raddr = (r_state == twgm_pkg::SOLVE_ROW_RD) ? {r_bank, CW'(0)}
                                                             : {r_bank, w_a1};
    assign w_lay_waddr = {~r_bank, r_a};
    assign w_lay_we    = (r_state == twgm_pkg::SOLVE_WRITE);
    assign w_lay_rdata = t_layer_word'(w_lay_rdata_raw);

    assign o_grid_raddr = (r_state == twgm_pkg::SOLVE_COL_RD) ? r_base + GAW'(r_a)
                                                              : r_base + GAW'(r_b);

    twgm_ram #(
        .DEPTH (2 ** LAW),
        .AW    (LAW),
        .DW    (LDW)
    ) u_layer_ram (
        .i_clk   (i_clk),
        .i_we    (w_lay_we),
        .i_waddr (w_lay_waddr),
        .i_wdata (LDW'(r_word)),
        .i_raddr (w_lay_raddr),
        .o_rdata (w_lay_rdata_raw)
    );

    assign w_win[0] = r_prev;
    assign w_win[1] = r_cur;
    assign w_win[2] = r_nxt;

    // off-grid neighbors read as zero; all totals are non-negative
    always_comb begin
        w_max9 = '0;
        for (int k = 0; k < 3; k++) begin
            if (w_win[k][r_b] > w_max9) begin
                w_max9 = w_win[k][r_b];
            end
            if (r_b != '0 && w_win[k][CW'(r_b - 1'b1)] > w_max9) begin
                w_max9 = w_win[k][CW'(r_b - 1'b1)];
            end
            if ((NW'(r_b) + 1'b1) < r_nc && w_win[k][CW'(r_b + 1'b1)] > w_max9) begin
                w_max9 = w_win[k][CW'(r_b + 1'b1)];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= twgm_pkg::SOLVE_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_status.busy   = (r_state != twgm_pkg::SOLVE_IDLE);
        o_status.done   = 1'b0;
        case (r_state)
            twgm_pkg::SOLVE_IDLE: begin
                if (i_start) begin
                    n_state = twgm_pkg::SOLVE_ROW_RD;
                end
            end
            twgm_pkg::SOLVE_ROW_RD:   n_state = twgm_pkg::SOLVE_ROW_LD;
            twgm_pkg::SOLVE_ROW_LD:   n_state = twgm_pkg::SOLVE_COL_RD;
            twgm_pkg::SOLVE_COL_RD:   n_state = twgm_pkg::SOLVE_COL_LD;
            twgm_pkg::SOLVE_COL_LD:   n_state = twgm_pkg::SOLVE_PAIR;
            twgm_pkg::SOLVE_PAIR: begin
                if (w_last_b) begin
                    n_state = twgm_pkg::SOLVE_PAIR_END;
                end
            end
            twgm_pkg::SOLVE_PAIR_END: n_state = twgm_pkg::SOLVE_WRITE;
            twgm_pkg::SOLVE_WRITE: begin
                if (r_row == '0) begin
                    o_status.done = 1'b1;
                    n_state       = twgm_pkg::SOLVE_IDLE;
                end else if (w_last_a) begin
                    n_state = twgm_pkg::SOLVE_ROW_RD;
                end else begin
                    n_state = twgm_pkg::SOLVE_COL_RD;
                end
            end
            default: n_state = twgm_pkg::SOLVE_IDLE;
        endcase
    end

    assign o_total = r_word[w_nc_m1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bd_vld <= 1'b0;
        end else begin
            r_bd_vld <= (r_state == twgm_pkg::SOLVE_PAIR);
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_d <= r_b;
        case (r_state)
            twgm_pkg::SOLVE_IDLE: begin
                r_row   <= RW'(i_rows - 1'b1);
                r_base  <= i_base;
                r_nc    <= i_cols;
                r_first <= 1'b1;
                r_bank  <= 1'b0;
            end
            twgm_pkg::SOLVE_ROW_LD: begin
                r_a    <= '0;
                r_cur  <= '0;
                r_nxt  <= r_first ? t_layer_word'(0) : w_lay_rdata;
            end
            twgm_pkg::SOLVE_COL_LD: begin
                r_prev <= r_cur;
                r_cur  <= r_nxt;
                r_nxt  <= (r_first || !w_a1_in) ? t_layer_word'(0) : w_lay_rdata;
                r_ga   <= i_grid_rdata;
                r_b    <= '0;
            end
            twgm_pkg::SOLVE_PAIR: begin
                r_best <= w_max9;
                if (!w_last_b) begin
                    r_b <= CW'(r_b + 1'b1);
                end
            end
            twgm_pkg::SOLVE_WRITE: begin
                if (w_last_a) begin
                    r_row   <= RW'(r_row - 1'b1);
                    r_base  <= r_base - GAW'(r_nc);
                    r_bank  <= ~r_bank;
                    r_first <= 1'b0;
                end else begin
                    r_a <= w_a1;
                end
            end
            default: ;
        endcase
        if (r_bd_vld) begin
            r_word[r_b_d] <= r_best + TW'(r_ga)
                           + ((r_a != r_b_d) ? TW'(i_grid_rdata) : TW'(0));
        end
    end

endmodule

>>> src/two_walker_grid_max_collect.sv
// ----------------------------------------------------------------------------
// two_walker_grid_max_collect
// Two-walker grid collector: stores a row-major grid, then finds the best
// combined pickup of two walkers moving down from the top corners.
// ----------------------------------------------------------------------------
// Cells are taken one per cycle into the grid RAM. The cell that completes
// row_count x col_count starts the solver, which runs one column pair per
// cycle. Input is stalled during the solve, and a completing cell is also
// held while the previous total waits at the output.
module two_walker_grid_max_collect #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [twgm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [twgm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [twgm_pkg::VALUE_W-1:0]      i_cell_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [twgm_pkg::TOTAL_W-1:0]      o_best_total
);

    localparam int GD  = MAX_ROWS * MAX_COLS;
    localparam int GAW = (GD > 1) ? $clog2(GD) : 1;
    localparam int CLW = $clog2(GD + 1);
    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int NW  = $clog2(MAX_COLS + 1);

    logic [twgm_pkg::ROWS_CFG_W-1:0] r_row_count;
    logic [twgm_pkg::COLS_CFG_W-1:0] r_col_count;
    logic [CLW-1:0]                  r_loaded;
    logic                            r_out_valid;
    logic [twgm_pkg::TOTAL_W-1:0]    r_best_total;

    logic [RW-1:0]                   w_rows;
    logic [NW-1:0]                   w_cols;
    logic [CLW-1:0]                  w_total;
    logic                            w_next_done;
    logic                            w_in_accept;
    logic                            w_out_accept;
    logic                            w_start;
    logic [GAW-1:0]                  w_grid_raddr;
    logic [twgm_pkg::VALUE_W-1:0]    w_grid_rdata;
    logic [twgm_pkg::TOTAL_W-1:0]    w_solve_total;
    twgm_pkg::t_solve_status         w_status;

    always_comb begin
        if (r_row_count == '0) begin
            w_rows = RW'(1);
        end else if (32'(r_row_count) > MAX_ROWS) begin
            w_rows = RW'(MAX_ROWS);
        end else begin
            w_rows = RW'(r_row_count);
        end
        if (r_col_count == '0) begin
            w_cols = NW'(1);
        end else if (32'(r_col_count) > MAX_COLS) begin
            w_cols = NW'(MAX_COLS);
        end else begin
            w_cols = NW'(r_col_count);
        end
    end

    assign w_total      = CLW'(w_rows) * CLW'(w_cols);
    assign w_next_done  = (CLW'(r_loaded + 1'b1) >= w_total);
    assign o_in_stall   = w_status.busy || (r_out_valid && w_next_done);
    assign w_in_accept  = i_in_valid && !o_in_stall;
    assign w_out_accept = r_out_valid && !i_out_stall;
    assign w_start      = w_in_accept && w_next_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= twgm_pkg::ROWS_RESET;
            r_col_count <= twgm_pkg::COLS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                twgm_pkg::CFG_ROW_COUNT: r_row_count <= i_cfg_data[twgm_pkg::ROWS_CFG_W-1:0];
                twgm_pkg::CFG_COL_COUNT: r_col_count <= i_cfg_data[twgm_pkg::COLS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= '0;
        end else if (w_in_accept) begin
            r_loaded <= w_next_done ? CLW'(0) : CLW'(r_loaded + 1'b1);
        end
    end

    twgm_ram #(
        .DEPTH (GD),
        .AW    (GAW),
        .DW    (twgm_pkg::VALUE_W)
    ) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_accept && (32'(r_loaded) < GD)),
        .i_waddr (GAW'(r_loaded)),
        .i_wdata (i_cell_value),
        .i_raddr (w_grid_raddr),
        .o_rdata (w_grid_rdata)
    );

    twgm_solver #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_solver (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_rows       (w_rows),
        .i_cols       (w_cols),
        .i_base       (GAW'(w_total - CLW'(w_cols))),
        .o_grid_raddr (w_grid_raddr),
        .i_grid_rdata (w_grid_rdata),
        .o_status     (w_status),
        .o_total      (w_solve_total)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_status.done) begin
            r_out_valid <= 1'b1;
        end else if (w_out_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_status.done) begin
            r_best_total <= w_solve_total;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_best_total = r_best_total;

    a_done_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.done |-> (!r_out_valid || !i_out_stall))
        else $error("solve finished while previous total still pending");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> w_status.busy)
        else $error("solver did not start on completing cell");

    a_no_load_in_solve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.busy |=> $stable(r_loaded))
        else $error("load count moved during solve");

    a_loaded_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_loaded) < GD)
        else $error("load count reached grid depth");

endmodule
